// ===== rtl/btok_pkg.sv =====
// Package: token, item and mode types plus character codes for the boolean expression tokenizer.
`timescale 1ns / 1ps

package btok_pkg;

  typedef enum logic [3:0] {
    TK_VAR   = 4'd0,
    TK_NOT   = 4'd1,
    TK_XOR   = 4'd2,
    TK_OR    = 4'd3,
    TK_AND   = 4'd4,
    TK_LP    = 4'd5,
    TK_RP    = 4'd6,
    TK_EQ    = 4'd7,
    TK_END   = 4'd8,
    TK_BADCH = 4'd9,
    TK_BADOP = 4'd10
  } tok_kind_t;

  typedef enum logic [3:0] {
    MODE_START  = 4'd0,
    MODE_LETTER = 4'd1,
    MODE_N      = 4'd2,
    MODE_NO     = 4'd3,
    MODE_X      = 4'd4,
    MODE_XO     = 4'd5,
    MODE_A      = 4'd6,
    MODE_AN     = 4'd7,
    MODE_O      = 4'd8,
    MODE_EQ     = 4'd9
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } char_item_t;

  typedef struct packed {
    tok_kind_t  token_kind;
    logic [7:0] var_letter;
    logic       last_of_run;
  } token_t;

  // Decoder verdict for one character: up to two tokens plus next state.
  typedef struct packed {
    logic [1:0] n_emit;
    token_t     tok0;
    token_t     tok1;
    scan_mode_t mode_next;
    logic [7:0] held_next;
    logic       halted_next;
  } btok_step_t;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_HT = 8'h09;
  localparam logic [7:0] CH_N  = 8'h6E;
  localparam logic [7:0] CH_O  = 8'h6F;
  localparam logic [7:0] CH_T  = 8'h74;
  localparam logic [7:0] CH_X  = 8'h78;
  localparam logic [7:0] CH_R  = 8'h72;
  localparam logic [7:0] CH_A  = 8'h61;
  localparam logic [7:0] CH_D  = 8'h64;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_LP = 8'h28;
  localparam logic [7:0] CH_RP = 8'h29;

endpackage

// ===== rtl/btok_decode.sv =====
// Combinational character decoder: current scan state and one character to tokens and next state.
`timescale 1ns / 1ps

module btok_decode (
  input  btok_pkg::char_item_t item,
  input  btok_pkg::scan_mode_t mode,
  input  logic [7:0]           held,
  input  logic                 halted,
  output btok_pkg::btok_step_t step
);
  import btok_pkg::*;

  typedef struct packed {
    logic       emit;
    tok_kind_t  kind;
    scan_mode_t mode;
    logic [7:0] held;
    logic       halt;
  } start_res_t;

  logic [7:0] c;
  logic       eoi;
  logic       blank;
  logic       alpha;
  logic       sep;
  start_res_t sr_sep;
  start_res_t sr_idle;

  // Character seen from the start mode.
  function automatic start_res_t start_step(input logic [7:0] ch, input logic eo,
                                            input logic is_blank, input logic is_alpha,
                                            input logic [7:0] held_in);
    start_res_t r;
    r.emit = 1'b0;
    r.kind = TK_VAR;
    r.mode = MODE_START;
    r.held = held_in;
    r.halt = 1'b0;
    if (eo) begin
      r.emit = 1'b1;
      r.kind = TK_END;
      r.halt = 1'b1;
    end else if (!is_blank) begin
      unique case (ch)
        CH_N: begin
          r.mode = MODE_N;
          r.held = ch;
        end
        CH_X: begin
          r.mode = MODE_X;
          r.held = ch;
        end
        CH_A: begin
          r.mode = MODE_A;
          r.held = ch;
        end
        CH_O: begin
          r.mode = MODE_O;
          r.held = ch;
        end
        CH_LP: begin
          r.emit = 1'b1;
          r.kind = TK_LP;
        end
        CH_RP: begin
          r.emit = 1'b1;
          r.kind = TK_RP;
        end
        CH_EQ: begin
          r.mode = MODE_EQ;
          r.held = 8'h00;
        end
        default: begin
          if (is_alpha) begin
            r.mode = MODE_LETTER;
            r.held = ch;
          end else begin
            r.emit = 1'b1;
            r.kind = TK_BADCH;
            r.halt = 1'b1;
            r.held = 8'h00;
          end
        end
      endcase
    end
    return r;
  endfunction

  assign c     = item.char_byte;
  assign eoi   = item.end_of_input;
  assign blank = (c == CH_SP) || (c == CH_CR) || (c == CH_LF) || (c == CH_HT);
  assign alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  assign sep   = eoi || (c == CH_LP) || (c == CH_RP) || blank;

  assign sr_sep  = start_step(c, eoi, blank, alpha, 8'h00);
  assign sr_idle = start_step(c, eoi, blank, alpha, held);

  always_comb begin
    step             = '0;
    step.tok0.token_kind = TK_VAR;
    step.tok1.token_kind = TK_VAR;
    step.mode_next   = mode;
    step.held_next   = held;
    step.halted_next = halted;

    if (!halted) begin
      unique case (mode) inside
        MODE_LETTER, MODE_N, MODE_X, MODE_A, MODE_O: begin
          if (sep) begin
            // Separator closes the held letter as a variable.
            step.n_emit          = 2'd1;
            step.tok0.token_kind = TK_VAR;
            step.tok0.var_letter = held;
            step.mode_next       = MODE_START;
            step.held_next       = 8'h00;
            if (eoi || !blank) begin
              step.mode_next   = sr_sep.mode;
              step.held_next   = sr_sep.held;
              step.halted_next = sr_sep.halt;
              if (sr_sep.emit) begin
                step.n_emit          = 2'd2;
                step.tok1.token_kind = sr_sep.kind;
              end
            end
          end else if (mode == MODE_LETTER) begin
            step.n_emit          = 2'd1;
            step.tok0.token_kind = TK_BADCH;
            step.mode_next       = MODE_START;
            step.held_next       = 8'h00;
            step.halted_next     = 1'b1;
          end else if (mode == MODE_N && c == CH_O) begin
            step.mode_next = MODE_NO;
          end else if (mode == MODE_X && c == CH_O) begin
            step.mode_next = MODE_XO;
          end else if (mode == MODE_A && c == CH_N) begin
            step.mode_next = MODE_AN;
          end else if (mode == MODE_O && c == CH_R) begin
            step.n_emit          = 2'd1;
            step.tok0.token_kind = TK_OR;
            step.mode_next       = MODE_START;
            step.held_next       = 8'h00;
          end else begin
            step.n_emit          = 2'd1;
            step.tok0.token_kind = TK_BADOP;
            step.mode_next       = MODE_START;
            step.held_next       = 8'h00;
            step.halted_next     = 1'b1;
          end
        end
        MODE_NO, MODE_XO, MODE_AN, MODE_EQ: begin
          step.n_emit    = 2'd1;
          step.mode_next = MODE_START;
          step.held_next = 8'h00;
          if (!eoi && mode == MODE_NO && c == CH_T) begin
            step.tok0.token_kind = TK_NOT;
          end else if (!eoi && mode == MODE_XO && c == CH_R) begin
            step.tok0.token_kind = TK_XOR;
          end else if (!eoi && mode == MODE_AN && c == CH_D) begin
            step.tok0.token_kind = TK_AND;
          end else if (!eoi && mode == MODE_EQ && c == CH_EQ) begin
            step.tok0.token_kind = TK_EQ;
          end else begin
            step.tok0.token_kind = TK_BADOP;
            step.halted_next     = 1'b1;
          end
        end
        default: begin
          step.mode_next   = sr_idle.mode;
          step.held_next   = sr_idle.held;
          step.halted_next = sr_idle.halt;
          if (sr_idle.emit) begin
            step.n_emit          = 2'd1;
            step.tok0.token_kind = sr_idle.kind;
          end
        end
      endcase
    end

    // Flag the final token of this character.
    if (step.n_emit == 2'd1) begin
      step.tok0.last_of_run = 1'b1;
    end
    if (step.n_emit == 2'd2) begin
      step.tok1.last_of_run = 1'b1;
    end
  end

endmodule

// ===== rtl/btok_fifo.sv =====
// Token queue: takes up to two tokens a cycle, gives one a cycle while pop is asserted.
`timescale 1ns / 1ps

module btok_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_n,
  input  btok_pkg::token_t push0,
  input  btok_pkg::token_t push1,
  input  logic             pop,
  output btok_pkg::token_t head,
  output logic             not_empty,
  output logic             room2,
  output logic [btok_pkg::PTR_W:0] level
);
  import btok_pkg::*;

  token_t                mem [FIFO_DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [PTR_W-1:0]      wr_ptr1;
  logic [PTR_W:0]        level_next;
  logic                  do_pop;

  assign wr_ptr1    = wr_ptr + PTR_W'(1);
  assign not_empty  = (level != '0);
  assign do_pop     = pop && not_empty;
  assign room2      = (level <= (PTR_W + 1)'(FIFO_DEPTH - 2));
  assign head       = mem[rd_ptr];
  assign level_next = level + (PTR_W + 1)'(push_n) - (PTR_W + 1)'(do_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr1] <= push1;
    end
  end

endmodule

// ===== rtl/boolean_expression_tokenizer.sv =====
// Top level of the boolean expression tokenizer: input stage, scan state, token queue.
//
//   channel  | valid      | stall      | payload              | dir
//   ---------+------------+------------+----------------------+-----
//   chars    | char_valid | char_stall | char_item (char_item_t) | in
//   tokens   | tok_valid  | tok_stall  | tok_item  (token_t)     | out
//
// One character is taken per cycle while char_stall is low. It sits in the input
// stage, where the decoder turns it into zero, one or two tokens that go into a
// four-entry queue. The input stage advances only while the queue has room for two
// tokens; that room check sets char_stall. Characters that yield two tokens are
// drained one token per cycle while tok_stall is low. rst (synchronous) empties
// stage and queue and returns to the start mode.
`timescale 1ns / 1ps

module boolean_expression_tokenizer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_stall,
  input  btok_pkg::char_item_t char_item,
  output logic                 tok_valid,
  input  logic                 tok_stall,
  output btok_pkg::token_t     tok_item
);
  import btok_pkg::*;

  // Input stage.
  logic       stage_valid;
  logic       stage_valid_next;
  char_item_t stage_item;

  // Scan state.
  scan_mode_t mode;
  logic [7:0] held;
  logic       halted;

  btok_step_t     step;
  logic           advance;
  logic           char_xfer;
  logic [1:0]     push_n;
  logic           room2;
  logic [PTR_W:0] level;

  // Stage moves into the queue only when two slots are free.
  assign advance          = stage_valid && room2;
  assign char_stall       = stage_valid && !room2;
  assign char_xfer        = char_valid && !char_stall;
  assign stage_valid_next = char_xfer || (stage_valid && !advance);
  assign push_n           = advance ? step.n_emit : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (char_xfer) begin
      stage_item <= char_item;
    end
  end

  // State commits when the staged character is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_START;
      held   <= 8'h00;
      halted <= 1'b0;
    end else if (advance) begin
      mode   <= step.mode_next;
      held   <= step.held_next;
      halted <= step.halted_next;
    end
  end

  btok_decode u_decode (
    .item   (stage_item),
    .mode   (mode),
    .held   (held),
    .halted (halted),
    .step   (step)
  );

  btok_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push0     (step.tok0),
    .push1     (step.tok1),
    .pop       (!tok_stall),
    .head      (tok_item),
    .not_empty (tok_valid),
    .room2     (room2),
    .level     (level)
  );

`ifndef SYNTHESIS
  // Queue never holds more than its depth.
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= (PTR_W + 1)'(FIFO_DEPTH))
    else $error("token queue overflow");

  // Nothing is queued after an end or error token.
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    halted |-> push_n == 2'd0)
    else $error("token pushed while halted");

  // A pushed token is visible on the next cycle.
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    push_n != 2'd0 |=> tok_valid)
    else $error("pushed token not presented");

  // Stall is only raised with a character held in the stage.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> stage_valid && level > (PTR_W + 1)'(FIFO_DEPTH - 2))
    else $error("spurious input stall");
`endif

endmodule
